// ----- hdl/smart_card_atr_parser_core_defines.svh -----
// Assertion macros used by the smart-card ATR parser core.
`ifndef SMART_CARD_ATR_PARSER_CORE_DEFINES_SVH
`define SMART_CARD_ATR_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define ATRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ATRP_ASSERT_NOW(lbl, ante, cons, msg)

`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/atrp_pkg.sv -----
// Types and constants of the smart-card ATR parser.
`timescale 1ns / 1ps

package atrp_pkg;

    localparam logic [2:0] KIND_TS   = 3'd0;
    localparam logic [2:0] KIND_T0   = 3'd1;
    localparam logic [2:0] KIND_TA   = 3'd2;
    localparam logic [2:0] KIND_TB   = 3'd3;
    localparam logic [2:0] KIND_TC   = 3'd4;
    localparam logic [2:0] KIND_TD   = 3'd5;
    localparam logic [2:0] KIND_HIST = 3'd6;
    localparam logic [2:0] KIND_SURP = 3'd7;

    localparam logic [5:0] MAX_BYTES_RESET = 6'd32;
    localparam logic [5:0] COUNT_MAX       = 6'd63;
    localparam logic [3:0] GROUP_MAX       = 4'd15;

    typedef enum logic [4:0] {
        PH_TS    = 5'b00001,
        PH_T0    = 5'b00010,
        PH_IFACE = 5'b00100,
        PH_HIST  = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_of_atr;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] byte_kind;
        logic [3:0] group_index;
        logic [3:0] protocol_type;
        logic       atr_complete;
        logic       pts_needed;
    } out_beat_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] pending;
        logic [3:0] group;
        logic [5:0] iface_count;
        logic [3:0] hist_total;
        logic [3:0] hist_left;
        logic [7:0] first_ta;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:       PH_TS,
        pending:     4'd0,
        group:       4'd0,
        iface_count: 6'd0,
        hist_total:  4'd0,
        hist_left:   4'd0,
        first_ta:    8'd0
    };

endpackage

// ----- hdl/atrp_step.sv -----
// Next-state and result logic for one ATR byte.
`timescale 1ns / 1ps

module atrp_step (
    input  atrp_pkg::parse_state_t cur,
    input  atrp_pkg::in_beat_t     in_data,
    input  logic [5:0]             max_bytes,
    output atrp_pkg::parse_state_t nxt,
    output atrp_pkg::out_beat_t    res
);

    atrp_pkg::parse_state_t s;
    logic                   try_open;
    logic                   leave;
    logic                   done;
    logic [3:0]             nib;
    logic [6:0]             used;

    always_comb
    begin
        s        = in_data.start_of_atr ? atrp_pkg::STATE_CLEAR : cur;
        nxt      = s;
        res      = '0;
        res.byte_kind = atrp_pkg::KIND_SURP;
        try_open = 1'b0;
        leave    = 1'b0;
        done     = 1'b0;
        nib      = in_data.rx_byte[7:4];

        unique case (s.phase)
            atrp_pkg::PH_TS:
            begin
                res.byte_kind = atrp_pkg::KIND_TS;
                nxt.phase     = atrp_pkg::PH_T0;
            end
            atrp_pkg::PH_T0:
            begin
                res.byte_kind  = atrp_pkg::KIND_T0;
                nxt.hist_total = in_data.rx_byte[3:0];
                nxt.hist_left  = in_data.rx_byte[3:0];
                nxt.group      = 4'd0;
                try_open       = 1'b1;
            end
            atrp_pkg::PH_IFACE:
            begin
                res.group_index = s.group;
                if (s.iface_count != atrp_pkg::COUNT_MAX)
                begin
                    nxt.iface_count = s.iface_count + 6'd1;
                end
                priority if (s.pending[0])
                begin
                    res.byte_kind  = atrp_pkg::KIND_TA;
                    nxt.pending[0] = 1'b0;
                    if (s.group == 4'd1)
                    begin
                        nxt.first_ta = in_data.rx_byte;
                    end
                end
                else if (s.pending[1])
                begin
                    res.byte_kind  = atrp_pkg::KIND_TB;
                    nxt.pending[1] = 1'b0;
                end
                else if (s.pending[2])
                begin
                    res.byte_kind  = atrp_pkg::KIND_TC;
                    nxt.pending[2] = 1'b0;
                end
                else
                begin
                    res.byte_kind     = atrp_pkg::KIND_TD;
                    nxt.pending       = 4'd0;
                    res.protocol_type = in_data.rx_byte[3:0];
                    try_open          = 1'b1;
                end
                if (!try_open && nxt.pending == 4'd0)
                begin
                    leave = 1'b1;
                end
            end
            atrp_pkg::PH_HIST:
            begin
                res.byte_kind = atrp_pkg::KIND_HIST;
                if (s.hist_left != 4'd0)
                begin
                    nxt.hist_left = s.hist_left - 4'd1;
                end
                if (nxt.hist_left == 4'd0)
                begin
                    nxt.phase = atrp_pkg::PH_DONE;
                    done      = 1'b1;
                end
            end
            default:
            begin
                res.byte_kind = atrp_pkg::KIND_SURP;
                nxt.phase     = atrp_pkg::PH_DONE;
            end
        endcase

        used = {1'b0, nxt.iface_count} + {3'b000, nxt.hist_total};

        if (try_open)
        begin
            if (nib != 4'd0 && nxt.group != atrp_pkg::GROUP_MAX &&
                used <= {1'b0, max_bytes})
            begin
                nxt.pending = nib;
                nxt.group   = nxt.group + 4'd1;
                nxt.phase   = atrp_pkg::PH_IFACE;
            end
            else
            begin
                leave = 1'b1;
            end
        end

        if (leave)
        begin
            nxt.pending = 4'd0;
            if (nxt.hist_left != 4'd0)
            begin
                nxt.phase = atrp_pkg::PH_HIST;
            end
            else
            begin
                nxt.phase = atrp_pkg::PH_DONE;
                done      = 1'b1;
            end
        end

        res.atr_complete = done;
        res.pts_needed   = (nxt.first_ta != 8'h00) && (nxt.first_ta != 8'h01) &&
                           (nxt.first_ta != 8'h11);
    end

endmodule

// ----- hdl/smart_card_atr_parser_core.sv -----
// Top level of the smart-card ATR parser with state and result registers.
// A byte accepted at a clock edge has its result registered and valid right after that edge.
// Throughput is one byte per cycle while no result waits or out_ready is high; atrp_step is combinational.
// The next byte is accepted while a result waits, as long as that result is taken too.
// Reset clears the parse state to expect TS and sets the limit register to 32.
`timescale 1ns / 1ps
`include "smart_card_atr_parser_core_defines.svh"

module smart_card_atr_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  atrp_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output atrp_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [5:0]          cfg_wdata
);

    atrp_pkg::parse_state_t state_reg;
    atrp_pkg::parse_state_t state_next;
    atrp_pkg::out_beat_t    result_reg;
    atrp_pkg::out_beat_t    result_next;
    logic                   out_valid_reg;
    logic [5:0]             max_bytes_reg;
    logic                   accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    atrp_step u_step (
        .cur       (state_reg),
        .in_data   (in_data),
        .max_bytes (max_bytes_reg),
        .nxt       (state_next),
        .res       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atrp_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
            max_bytes_reg <= atrp_pkg::MAX_BYTES_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_bytes_reg <= cfg_wdata;
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    `ATRP_ASSERT_NEXT(a_accept_gives_beat, accept, out_valid, "accepted beat gave no result")
    `ATRP_ASSERT_NOW(a_complete_kind, out_valid && out_data.atr_complete, out_data.byte_kind != atrp_pkg::KIND_TS && out_data.byte_kind != atrp_pkg::KIND_SURP, "completion on TS or surplus byte")
    `ATRP_ASSERT_NOW(a_group_kind, out_valid && out_data.group_index != 4'd0, out_data.byte_kind == atrp_pkg::KIND_TA || out_data.byte_kind == atrp_pkg::KIND_TB || out_data.byte_kind == atrp_pkg::KIND_TC || out_data.byte_kind == atrp_pkg::KIND_TD, "group index on non-interface byte")

endmodule
